[src/dpt_pkg.sv]
// Shared types, constants and codes for the dual policy task picker.
package dpt_pkg;

    localparam int DEF_TASK_SLOTS = 8;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    localparam logic [1:0] KIND_RECOVERY     = 2'd1;
    localparam logic [1:0] KIND_EXPERIMENTAL = 2'd2;
    localparam logic [1:0] MODE_SAFE         = 2'd0;
    localparam logic [1:0] MODE_DEGRADED     = 2'd1;
    localparam logic [1:0] MODE_NORMAL       = 2'd2;

    localparam logic [1:0] REG_BASE_MODE = 2'd0;
    localparam logic [1:0] REG_SLOTS     = 2'd1;
    localparam logic [1:0] REG_CAPACITY  = 2'd2;

    localparam logic [1:0] SRC_RATIONAL = 2'd0;
    localparam logic [1:0] SRC_CREATIVE = 2'd1;
    localparam logic [1:0] SRC_DIVERGE  = 2'd2;
    localparam logic [1:0] SRC_AGREE    = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  slot;
        logic [1:0]  task_kind;
        logic [15:0] energy_in;
        logic [15:0] due_time;
    } cmd_t;

    typedef struct packed {
        logic        idle;
        logic [2:0]  picked_slot;
        logic [15:0] energy_left;
        logic        task_finished;
        logic [1:0]  picker_source;
        logic        diverged;
        logic [6:0]  pressure_percent;
        logic [1:0]  mode_now;
        logic        mode_dropped;
        logic [2:0]  pressure_level;
        logic        all_finished;
        logic [15:0] tick_number;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV1_WAIT,
        ST_CHECK,
        ST_SCAN,
        ST_UPDATE,
        ST_DIV2,
        ST_DIV2_WAIT,
        ST_DONE
    } state_t;

    // percent to pressure level, thresholds 30/50/70/90
    function automatic logic [2:0] level_of(input logic [6:0] pct);
        logic [2:0] lv;
        begin
            if (pct < 7'd30)      lv = 3'd0;
            else if (pct < 7'd50) lv = 3'd1;
            else if (pct < 7'd70) lv = 3'd2;
            else if (pct < 7'd90) lv = 3'd3;
            else                  lv = 3'd4;
            return lv;
        end
    endfunction

endpackage

[src/dpt_div.sv]
// Restoring divider, one quotient bit per cycle, for used*100/capacity.
module dpt_div
    import dpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [23:0] used,
    input  logic [23:0] cap,
    output logic        done,
    output logic [6:0]  pct
);
    // dividend used*100 fits 31 bits
    localparam int DW = 31;

    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [24:0]   rem_reg, rem_next;
    logic [23:0]   dsr_reg, dsr_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [24:0]   shifted;
    logic [30:0]   prod;

    assign prod = {7'd0, used} * 31'd100;
    assign shifted = {rem_reg[23:0], dvd_reg[DW-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            dvd_next = prod;
            dsr_next = (cap == 24'd0) ? 24'd1 : cap;
            rem_next = '0;
            quo_next = '0;
            cnt_next = 5'(DW - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = shifted - {1'b0, dsr_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign pct  = (quo_reg > 31'd100) ? 7'd100 : quo_reg[6:0];
endmodule

[src/dual_policy_task_picker_top.sv]
// Top level of the dual policy task picker: task table, sequencer and result.
//
// Issue a command with start while busy is low; one result per command comes
// back on result with done high for exactly one cycle, and the receiver cannot
// stall it. Loads, restarts and unused opcodes go from IDLE straight to DONE.
// A tick runs DIV1, DIV1_WAIT and CHECK; CHECK goes to DONE when every slot
// in use (capped at TASK_SLOTS) is done, else to SCAN over the slots in use
// and then UPDATE, and an idle tick runs DIV2 and DIV2_WAIT before DONE.
// The shared bit-serial divider (31 quotient bits) runs once for
// the pressure percent before the scan and again after an idle tick frees
// memory, and the slot scan steps through one slot per cycle feeding both
// pickers. Configuration writes are taken at any time (cfg_ready is tied
// high) but are meant to occur only while idle.
module dual_policy_task_picker_top
    import dpt_pkg::*;
#(
    parameter int TASK_SLOTS = DEF_TASK_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    // configuration
    logic [1:0]  base_mode_reg;
    logic [3:0]  slots_reg;
    logic [23:0] cap_reg;

    // task store
    logic [1:0]  kind_mem [TASK_SLOTS];
    logic [15:0] energy_mem [TASK_SLOTS];
    logic [15:0] dead_mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] done_flags_reg;

    logic [15:0] time_reg;
    logic [1:0]  mode_reg;
    logic [23:0] used_reg;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;
    result_t res_reg;
    logic   done_reg;

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] n_active;
    logic [6:0]    pct_reg;
    logic [2:0]    lvl_reg;
    logic          drop_reg;
    logic          skip_tick_reg;
    logic [15:0]   e_left_reg;

    // picker registers
    logic          r_ok_reg, c_ok_reg;
    logic [SW-1:0] r_idx_reg, c_idx_reg;
    logic signed [17:0] r_score_reg;
    logic [16:0]   c_score_reg;

    // divider
    logic       div_go;
    logic       div_done;
    logic [6:0] div_pct;

    logic       load_ok;

    dpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .used  (used_reg),
        .cap   (cap_reg),
        .done  (div_done),
        .pct   (div_pct)
    );

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign result = res_reg;

    // drop loads aimed past the table
    assign load_ok = (int'(cmd.slot) < TASK_SLOTS);

    always_comb
    begin
        if (int'(slots_reg) > TASK_SLOTS) n_active = CW'(TASK_SLOTS);
        else                              n_active = CW'(slots_reg);
    end

    // every-slot-done test over slots in use
    logic slots_all_done;
    always_comb
    begin
        slots_all_done = 1'b1;
        for (int i = 0; i < TASK_SLOTS; i++)
        begin
            if ((CW'(i) < n_active) && !done_flags_reg[i]) slots_all_done = 1'b0;
        end
    end

    // current scan element
    logic [SW-1:0] si;
    logic [1:0]  s_kind;
    logic [15:0] s_energy;
    logic [15:0] s_dead;
    logic        s_live, s_gate, r_elig, c_elig;
    logic signed [17:0] slack, r_score;
    logic [16:0] c_score;

    assign si = idx_reg[SW-1:0];
    assign s_kind = kind_mem[si];
    assign s_energy = energy_mem[si];
    assign s_dead = dead_mem[si];

    always_comb
    begin
        s_live = !done_flags_reg[si] && (s_energy != 16'd0);
        s_gate = !((s_kind == KIND_EXPERIMENTAL) &&
                   ((mode_reg == MODE_SAFE) || (lvl_reg >= 3'd3)));
        slack = $signed({2'b00, s_dead}) - $signed({2'b00, time_reg});
        r_score = slack + $signed({2'b00, s_energy});
        r_elig = s_live && s_gate;
        if (mode_reg == MODE_SAFE)
        begin
            if (s_kind == KIND_EXPERIMENTAL) r_elig = 1'b0;
            if ((s_kind != KIND_RECOVERY) && (slack > 18'sd5)) r_elig = 1'b0;
        end
        else if (mode_reg == MODE_DEGRADED)
        begin
            if (s_kind == KIND_EXPERIMENTAL) r_elig = 1'b0;
            if (slack > 18'sd15) r_elig = 1'b0;
        end
        c_elig = s_live && s_gate && (mode_reg != MODE_SAFE) && (lvl_reg < 3'd2);
        c_score = {1'b0, s_energy} + ((s_kind == KIND_EXPERIMENTAL) ? 17'd100 : 17'd0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    if (opcode_t'(cmd.opcode) == OP_TICK) state_next = ST_DIV1;
                    else                                  state_next = ST_DONE;
                end
            ST_DIV1:      state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (div_done) state_next = ST_CHECK;
            ST_CHECK:     state_next = slots_all_done ? ST_DONE : ST_SCAN;
            ST_SCAN:      if (idx_reg >= n_active) state_next = ST_UPDATE;
            ST_UPDATE:    state_next = (r_ok_reg || c_ok_reg) ? ST_DONE : ST_DIV2;
            ST_DIV2:      state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT: if (div_done) state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        div_go = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg <= MODE_NORMAL;
            slots_reg     <= 4'd0;
            cap_reg       <= 24'd8388608;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_MODE: base_mode_reg <= (cfg_data[1:0] == 2'd3) ? MODE_NORMAL
                                                                        : cfg_data[1:0];
                REG_SLOTS:     slots_reg <= cfg_data[3:0];
                REG_CAPACITY:  cap_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // task store writes: load, and energy spend of the chosen task
    logic          any_pick;
    logic [SW-1:0] chosen;
    logic [15:0]   e_new;
    assign any_pick = r_ok_reg || c_ok_reg;
    assign chosen = r_ok_reg ? r_idx_reg : c_idx_reg;
    assign e_new = energy_mem[chosen] - 16'd1;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && opcode_t'(cmd.opcode) == OP_LOAD && load_ok)
        begin
            kind_mem[SW'(cmd.slot)]   <= cmd.task_kind;
            energy_mem[SW'(cmd.slot)] <= cmd.energy_in;
            dead_mem[SW'(cmd.slot)]   <= cmd.due_time;
        end
        else if (state_reg == ST_UPDATE && any_pick)
        begin
            energy_mem[chosen] <= e_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start) cmd_reg <= cmd;
    end

    // which picker the tick followed
    logic [1:0] src_sel;
    logic       div_sel;
    always_comb
    begin
        if (!r_ok_reg)
        begin
            src_sel = SRC_CREATIVE;
            div_sel = 1'b1;
        end
        else if (c_ok_reg && r_idx_reg != c_idx_reg)
        begin
            src_sel = SRC_DIVERGE;
            div_sel = 1'b1;
        end
        else if (c_ok_reg)
        begin
            src_sel = SRC_AGREE;
            div_sel = 1'b0;
        end
        else
        begin
            src_sel = SRC_RATIONAL;
            div_sel = 1'b0;
        end
    end

    // result item for the done cycle; non-tick commands report idle only
    result_t res_next;
    always_comb
    begin
        res_next = '0;
        res_next.idle = 1'b1;
        if (opcode_t'(cmd_reg.opcode) == OP_TICK)
        begin
            res_next.pressure_percent = pct_reg;
            res_next.mode_now = mode_reg;
            res_next.pressure_level = lvl_reg;
            res_next.tick_number = time_reg;
            if (skip_tick_reg)
            begin
                res_next.all_finished = 1'b1;
            end
            else
            begin
                res_next.mode_dropped = drop_reg;
                if (any_pick)
                begin
                    res_next.idle          = 1'b0;
                    res_next.picked_slot   = 3'(chosen);
                    res_next.energy_left   = e_left_reg;
                    res_next.task_finished = (e_left_reg == 16'd0);
                    res_next.picker_source = src_sel;
                    res_next.diverged      = div_sel;
                end
            end
        end
    end

    // control state, scan and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_flags_reg <= '0;
            time_reg <= '0;
            mode_reg <= MODE_NORMAL;
            used_reg <= '0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            r_ok_reg <= 1'b0;
            c_ok_reg <= 1'b0;
            r_idx_reg <= '0;
            c_idx_reg <= '0;
            r_score_reg <= '0;
            c_score_reg <= '0;
            e_left_reg <= '0;
            drop_reg <= 1'b0;
            pct_reg  <= '0;
            lvl_reg  <= '0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (start && opcode_t'(cmd.opcode) == OP_LOAD && load_ok)
                    begin
                        done_flags_reg[SW'(cmd.slot)] <= 1'b0;
                    end
                ST_DIV1_WAIT:
                    if (div_done)
                    begin
                        pct_reg <= div_pct;
                        lvl_reg <= level_of(div_pct);
                    end
                ST_CHECK:
                begin
                    // apply downgrade, then start the scan
                    drop_reg <= 1'b0;
                    if (!slots_all_done)
                    begin
                        if (lvl_reg >= 3'd4 && mode_reg > MODE_SAFE)
                        begin
                            mode_reg <= MODE_SAFE;
                            drop_reg <= 1'b1;
                        end
                        else if (lvl_reg == 3'd3 && mode_reg > MODE_DEGRADED)
                        begin
                            mode_reg <= MODE_DEGRADED;
                            drop_reg <= 1'b1;
                        end
                    end
                    idx_reg  <= '0;
                    r_ok_reg <= 1'b0;
                    c_ok_reg <= 1'b0;
                end
                ST_SCAN:
                    if (idx_reg < n_active)
                    begin
                        if (r_elig && (!r_ok_reg || r_score < r_score_reg))
                        begin
                            r_ok_reg <= 1'b1;
                            r_idx_reg <= si;
                            r_score_reg <= r_score;
                        end
                        if (c_elig && (!c_ok_reg || c_score > c_score_reg))
                        begin
                            c_ok_reg <= 1'b1;
                            c_idx_reg <= si;
                            c_score_reg <= c_score;
                        end
                        idx_reg <= idx_reg + CW'(1);
                    end
                ST_UPDATE:
                    if (any_pick)
                    begin
                        if (e_new == 16'd0) done_flags_reg[chosen] <= 1'b1;
                        used_reg <= ({1'b0, used_reg} + 25'd512 > {1'b0, cap_reg})
                                    ? cap_reg : used_reg + 24'd512;
                        e_left_reg <= e_new;
                    end
                    else
                    begin
                        used_reg <= (used_reg >= 24'd1024) ? used_reg - 24'd1024 : 24'd0;
                    end
                ST_DIV2_WAIT:
                    if (div_done) pct_reg <= div_pct;
                ST_DONE:
                begin
                    done_reg <= 1'b1;
                    res_reg <= res_next;
                    if (opcode_t'(cmd_reg.opcode) == OP_RESTART)
                    begin
                        time_reg <= '0;
                        used_reg <= '0;
                        mode_reg <= base_mode_reg;
                        done_flags_reg <= '0;
                    end
                    else if (opcode_t'(cmd_reg.opcode) == OP_TICK && !skip_tick_reg)
                    begin
                        // advance time, holding at the top
                        if (time_reg != 16'hFFFF) time_reg <= time_reg + 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // remember that the tick was skipped because every slot was done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)                     skip_tick_reg <= 1'b0;
        else if (state_reg == ST_CHECK) skip_tick_reg <= slots_all_done;
    end
endmodule
